/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the console core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/tclb_pkg.sv */
// Package with the constants, types and helper functions of the text console line buffer.
package tclb_pkg;

  localparam int Columns   = 16;
  localparam int LineCount = 3;
  localparam int CellCount = LineCount * Columns;
  localparam int AddrW     = $clog2(CellCount);
  localparam int CntW      = $clog2(CellCount + 1);
  localparam int ColW      = 5;
  localparam int RowW      = 2;
  localparam int CharW     = 8;
  localparam int MaxDraws  = 49;
  localparam int EmitAll   = (CellCount < MaxDraws) ? CellCount : MaxDraws;

  localparam logic [CharW-1:0] SpaceCode = 8'd32;

  // Prosign keys and the letters they expand to.
  localparam logic [CharW-1:0] KeyB  = 8'h62;
  localparam logic [CharW-1:0] KeyA  = 8'h61;
  localparam logic [CharW-1:0] KeyK  = 8'h6B;
  localparam logic [CharW-1:0] KeyV  = 8'h76;
  localparam logic [CharW-1:0] LetA  = 8'h41;
  localparam logic [CharW-1:0] LetB  = 8'h42;
  localparam logic [CharW-1:0] LetK  = 8'h4B;
  localparam logic [CharW-1:0] LetN  = 8'h4E;
  localparam logic [CharW-1:0] LetR  = 8'h52;
  localparam logic [CharW-1:0] LetT  = 8'h54;
  localparam logic [CharW-1:0] LetV  = 8'h56;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_NEWLINE   = 2'd1,
    OP_BACKSPACE = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef struct packed {
    logic             two;
    logic [CharW-1:0] first;
    logic [CharW-1:0] second;
  } put_pair_t;

  // Turns a typed character into one or two characters to store.
  function automatic put_pair_t expand_char(input logic [CharW-1:0] ch);
    put_pair_t p;
    p.two    = 1'b1;
    p.first  = ch;
    p.second = ch;
    if (ch == KeyB) begin
      p.first  = LetB;
      p.second = LetT;
    end else if (ch == KeyA) begin
      p.first  = LetA;
      p.second = LetR;
    end else if (ch == KeyK) begin
      p.first  = LetK;
      p.second = LetN;
    end else if (ch == KeyV) begin
      p.first  = LetV;
      p.second = LetA;
    end else begin
      p.two = 1'b0;
    end
    return p;
  endfunction

  // Store address of a cell, lines stored top first.
  function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] row,
                                                 input logic [ColW-1:0] col);
    return AddrW'(int'(row) * Columns + int'(col));
  endfunction

endpackage

/* rtl/core/text_console_line_buffer_core.sv */
// Top level of the text console line buffer: text memory, sequencer and result register.
//
// Usage: an input beat carries one command in in_tuser (put character, newline,
// backspace, clear) and the character byte in in_tdata. Every command answers with
// zero or more cell redraw beats on the out channel (draw flag set in out_tuser)
// followed by one status beat with out_tlast high. All beats of a command carry the
// flag telling whether the cursor sits at column zero afterwards.
// One command is handled at a time. A put writes its characters, then reads back
// the changed cells for redraw; a scroll copies two lines through the text memory,
// which has one write and one read port, before the 48 redraws leave at one per
// cycle while the receiver accepts them; backspace at column zero first scans up
// to two lines. The memory read port, one access a cycle, bounds all of these.
// Clear sends its status beat without any memory access.
// Reset clears the cursor and marks every text cell as a space through per-cell
// valid bits; no clearing pass is needed, and clear works the same way.
// When the receiver stalls, the result register holds its beat and the sequencer
// waits; a new command is taken as soon as the last beat is in the result register.
module text_console_line_buffer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] column, [6:5] row, [14:7] glyph, [15] cursor_at_start
  output logic [0:0]  out_tuser,  // [0] draw_valid
  output logic        out_tlast   // last_result
);
  import tclb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_SCAN,
    S_MOVE,
    S_EMIT,
    S_STATUS
  } state_t;

  // Text memory: one write and one registered read per cycle.
  logic [CharW-1:0] text_mem_r [CellCount];
  logic [CharW-1:0] rd_q_r;
  logic             rd_vld_r;

  logic             mem_re, mem_we;
  logic [AddrW-1:0] mem_raddr, mem_waddr;
  logic [CharW-1:0] mem_wdata;

  state_t state_r, state_nxt;
  logic [CellCount-1:0] vld_r, vld_nxt;
  logic [ColW-1:0]  cursor_r, cursor_nxt;
  logic [CharW-1:0] ch1_r, ch1_nxt, ch2_r, ch2_nxt;
  logic             two_r, two_nxt;
  logic             all_dirty_r, all_dirty_nxt;
  logic [ColW-1:0]  dcol_r, dcol_nxt;
  logic [1:0]       dcnt_r, dcnt_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [ColW-1:0]  tag_col_r, tag_col_nxt;
  logic [RowW-1:0]  tag_row_r, tag_row_nxt;
  logic [AddrW-1:0] tag_waddr_r, tag_waddr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [AddrW-1:0] src_r, src_nxt, dst_r, dst_nxt;
  logic             down_r, down_nxt;
  logic [LineCount-1:0] clr_rows_r, clr_rows_nxt;
  logic             after_put_r, after_put_nxt;
  logic             bs_clear_r, bs_clear_nxt;
  logic [RowW-1:0]  scan_row_r, scan_row_nxt;
  logic             found_r, found_nxt;
  logic [ColW-1:0]  last_col_r, last_col_nxt;
  logic [ColW-1:0]  em_col_r, em_col_nxt;
  logic [RowW-1:0]  em_row_r, em_row_nxt;
  logic             em_full_r, em_full_nxt;

  logic             out_tvalid_r, out_tvalid_nxt;
  logic [ColW-1:0]  out_col_r, out_col_nxt;
  logic [RowW-1:0]  out_row_r, out_row_nxt;
  logic [CharW-1:0] out_glyph_r, out_glyph_nxt;
  logic             out_draw_r, out_draw_nxt;
  logic             out_start_r, out_start_nxt;
  logic             out_last_r, out_last_nxt;

  logic can_load;
  logic at_start;

  assign in_tready  = (state_r == S_IDLE);
  assign can_load   = !out_tvalid_r || out_tready;
  assign at_start   = (cursor_r == '0);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_start_r, out_glyph_r, out_row_r, out_col_r};
  assign out_tuser  = out_draw_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    put_pair_t        pair;
    logic             issue;
    logic [ColW-1:0]  pcol;
    logic [1:0]       pcnt;

    pair  = expand_char(in_tdata);
    issue = 1'b0;
    pcol  = (dcnt_r == 2'd0) ? cursor_r : dcol_r;
    pcnt  = dcnt_r + 2'd1;

    state_nxt     = state_r;
    vld_nxt       = vld_r;
    cursor_nxt    = cursor_r;
    ch1_nxt       = ch1_r;
    ch2_nxt       = ch2_r;
    two_nxt       = two_r;
    all_dirty_nxt = all_dirty_r;
    dcol_nxt      = dcol_r;
    dcnt_nxt      = dcnt_r;
    rd_pend_nxt   = 1'b0;
    tag_col_nxt   = tag_col_r;
    tag_row_nxt   = tag_row_r;
    tag_waddr_nxt = tag_waddr_r;
    cnt_nxt       = cnt_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    down_nxt      = down_r;
    clr_rows_nxt  = clr_rows_r;
    after_put_nxt = after_put_r;
    bs_clear_nxt  = bs_clear_r;
    scan_row_nxt  = scan_row_r;
    found_nxt     = found_r;
    last_col_nxt  = last_col_r;
    em_col_nxt    = em_col_r;
    em_row_nxt    = em_row_r;
    em_full_nxt   = em_full_r;

    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_glyph_nxt  = out_glyph_r;
    out_draw_nxt   = out_draw_r;
    out_start_nxt  = out_start_r;
    out_last_nxt   = out_last_r;

    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (op_t'(in_tuser))
            OP_PUT: begin
              ch1_nxt       = pair.first;
              ch2_nxt       = pair.second;
              two_nxt       = pair.two;
              all_dirty_nxt = 1'b0;
              dcnt_nxt      = 2'd0;
              state_nxt     = S_PUT;
            end
            OP_NEWLINE: begin
              src_nxt       = AddrW'(Columns);
              dst_nxt       = '0;
              down_nxt      = 1'b0;
              cnt_nxt       = CntW'(2 * Columns);
              clr_rows_nxt  = 3'b100;
              after_put_nxt = 1'b0;
              bs_clear_nxt  = 1'b0;
              cursor_nxt    = '0;
              state_nxt     = S_MOVE;
            end
            OP_BACKSPACE: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - 1'b1;
                vld_nxt[cell_addr(2'd2, cursor_r - 1'b1)] = 1'b0;
                em_full_nxt = 1'b0;
                em_col_nxt  = cursor_r - 1'b1;
                em_row_nxt  = 2'd2;
                cnt_nxt     = CntW'(1);
                state_nxt   = S_EMIT;
              end else begin
                // Look for text in the middle line first.
                scan_row_nxt = 2'd1;
                em_col_nxt   = '0;
                cnt_nxt      = CntW'(Columns);
                found_nxt    = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            OP_CLEAR: begin
              vld_nxt    = '0;
              cursor_nxt = '0;
              state_nxt  = S_STATUS;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_PUT: begin
        if (cursor_r == ColW'(Columns)) begin
          // Bottom line full: scroll up, then come back to store the character.
          src_nxt       = AddrW'(Columns);
          dst_nxt       = '0;
          down_nxt      = 1'b0;
          cnt_nxt       = CntW'(2 * Columns);
          clr_rows_nxt  = 3'b100;
          after_put_nxt = 1'b1;
          bs_clear_nxt  = 1'b0;
          all_dirty_nxt = 1'b1;
          cursor_nxt    = '0;
          state_nxt     = S_MOVE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(2'd2, cursor_r);
          mem_wdata = ch1_r;
          vld_nxt[cell_addr(2'd2, cursor_r)] = 1'b1;
          cursor_nxt = cursor_r + 1'b1;
          dcol_nxt   = pcol;
          dcnt_nxt   = pcnt;
          if (two_r) begin
            ch1_nxt = ch2_r;
            two_nxt = 1'b0;
          end else begin
            em_full_nxt = all_dirty_r;
            em_col_nxt  = all_dirty_r ? '0 : pcol;
            em_row_nxt  = all_dirty_r ? 2'd0 : 2'd2;
            cnt_nxt     = all_dirty_r ? CntW'(EmitAll) : CntW'(pcnt);
            state_nxt   = S_EMIT;
          end
        end
      end

      S_SCAN: begin
        // Ascending scan: the last non-space cell seen wins.
        if (rd_pend_r && rd_vld_r && (rd_q_r != SpaceCode)) begin
          found_nxt    = 1'b1;
          last_col_nxt = tag_col_r;
        end
        if (cnt_r != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = cell_addr(scan_row_r, em_col_r);
          tag_col_nxt = em_col_r;
          em_col_nxt  = em_col_r + 1'b1;
          cnt_nxt     = cnt_r - 1'b1;
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          if (found_r) begin
            cursor_nxt    = last_col_r;
            after_put_nxt = 1'b0;
            bs_clear_nxt  = 1'b1;
            state_nxt     = S_MOVE;
            if (scan_row_r == 2'd1) begin
              // Middle line moves down, top line to the middle.
              src_nxt      = AddrW'(2 * Columns - 1);
              dst_nxt      = AddrW'(3 * Columns - 1);
              down_nxt     = 1'b1;
              cnt_nxt      = CntW'(2 * Columns);
              clr_rows_nxt = 3'b001;
            end else begin
              // Top line moves to the bottom, the rest goes blank.
              src_nxt      = '0;
              dst_nxt      = AddrW'(2 * Columns);
              down_nxt     = 1'b0;
              cnt_nxt      = CntW'(Columns);
              clr_rows_nxt = 3'b011;
            end
          end else if (scan_row_r == 2'd1) begin
            scan_row_nxt = 2'd0;
            em_col_nxt   = '0;
            cnt_nxt      = CntW'(Columns);
            state_nxt    = S_SCAN;
          end else begin
            state_nxt = S_STATUS;
          end
        end
      end

      S_MOVE: begin
        // Read a source cell, then write the registered read data to its destination.
        if (rd_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = tag_waddr_r;
          mem_wdata = rd_q_r;
          vld_nxt[tag_waddr_r] = rd_vld_r;
        end
        if (cnt_r != '0) begin
          mem_re        = 1'b1;
          mem_raddr     = src_r;
          tag_waddr_nxt = dst_r;
          src_nxt       = down_r ? src_r - 1'b1 : src_r + 1'b1;
          dst_nxt       = down_r ? dst_r - 1'b1 : dst_r + 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
          rd_pend_nxt   = 1'b1;
        end else if (!rd_pend_r) begin
          for (int r = 0; r < LineCount; r++) begin
            if (clr_rows_r[r]) begin
              vld_nxt[r * Columns +: Columns] = '0;
            end
          end
          if (bs_clear_r) begin
            vld_nxt[cell_addr(2'd2, cursor_r)] = 1'b0;
          end
          if (after_put_r) begin
            state_nxt = S_PUT;
          end else begin
            em_full_nxt = 1'b1;
            em_col_nxt  = '0;
            em_row_nxt  = 2'd0;
            cnt_nxt     = CntW'(EmitAll);
            state_nxt   = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (rd_pend_r && can_load) begin
          out_tvalid_nxt = 1'b1;
          out_col_nxt    = tag_col_r;
          out_row_nxt    = tag_row_r + 1'b1;
          out_glyph_nxt  = rd_vld_r ? rd_q_r : SpaceCode;
          out_draw_nxt   = 1'b1;
          out_start_nxt  = at_start;
          out_last_nxt   = 1'b0;
        end
        issue = (cnt_r != '0) && (!rd_pend_r || can_load);
        if (issue) begin
          mem_re      = 1'b1;
          mem_raddr   = cell_addr(em_row_r, em_col_r);
          tag_col_nxt = em_col_r;
          tag_row_nxt = em_row_r;
          cnt_nxt     = cnt_r - 1'b1;
          if (em_full_r && (em_row_r != 2'd2)) begin
            em_row_nxt = em_row_r + 1'b1;
          end else begin
            em_row_nxt = em_full_r ? 2'd0 : em_row_r;
            em_col_nxt = em_col_r + 1'b1;
          end
        end
        rd_pend_nxt = issue || (rd_pend_r && !can_load);
        if ((cnt_r == '0) && !rd_pend_r) begin
          state_nxt = S_STATUS;
        end
      end

      S_STATUS: begin
        if (can_load) begin
          out_tvalid_nxt = 1'b1;
          out_col_nxt    = '0;
          out_row_nxt    = '0;
          out_glyph_nxt  = '0;
          out_draw_nxt   = 1'b0;
          out_start_nxt  = at_start;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r   <= text_mem_r[mem_raddr];
      rd_vld_r <= vld_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vld_r        <= '0;
      cursor_r     <= '0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vld_r        <= vld_nxt;
      cursor_r     <= cursor_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    ch1_r       <= ch1_nxt;
    ch2_r       <= ch2_nxt;
    two_r       <= two_nxt;
    all_dirty_r <= all_dirty_nxt;
    dcol_r      <= dcol_nxt;
    dcnt_r      <= dcnt_nxt;
    tag_col_r   <= tag_col_nxt;
    tag_row_r   <= tag_row_nxt;
    tag_waddr_r <= tag_waddr_nxt;
    cnt_r       <= cnt_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    down_r      <= down_nxt;
    clr_rows_r  <= clr_rows_nxt;
    after_put_r <= after_put_nxt;
    bs_clear_r  <= bs_clear_nxt;
    scan_row_r  <= scan_row_nxt;
    found_r     <= found_nxt;
    last_col_r  <= last_col_nxt;
    em_col_r    <= em_col_nxt;
    em_row_r    <= em_row_nxt;
    em_full_r   <= em_full_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_draw_r  <= out_draw_nxt;
    out_start_r <= out_start_nxt;
    out_last_r  <= out_last_nxt;
  end

`include "assert_macros.svh"

  // The status beat never claims to be a cell redraw.
  `ASSERT_SAME(a_last_not_draw, out_tvalid_r && out_last_r, !out_draw_r)
  // The cursor never passes the end of the line.
  `ASSERT_SAME(a_cursor_range, 1'b1, cursor_r <= ColW'(Columns))
  // An accepted command always leaves the idle state.
  `ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, state_r != S_IDLE)
  // Line copies never read and write the same cell in one cycle.
  `ASSERT_SAME(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr)

endmodule
